// ===== sv/imuaz_pkg.sv =====
// Package for the six-axis IMU offset auto-zero block.
// Transaction payload types, command codes, register indexes and per-axis result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imuaz_pkg;

  localparam int unsigned NUM_AXES   = 6;
  localparam int unsigned NUM_ACCEL  = 3;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned ACC_FAC_W  = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [NUM_AXES-1:0] ALL_AXES = '1;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST = LIMIT_W'(5);

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_X_FACTORY = 3'd0,
    REG_ACCEL_Y_FACTORY = 3'd1,
    REG_ACCEL_Z_FACTORY = 3'd2,
    REG_GYRO_X_FACTORY  = 3'd3,
    REG_GYRO_Y_FACTORY  = 3'd4,
    REG_GYRO_Z_FACTORY  = 3'd5,
    REG_ERROR_LIMIT     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_t;

  typedef struct packed {
    logic [15:0] accel_x_word;
    logic [15:0] accel_y_word;
    logic [15:0] accel_z_word;
    logic [15:0] gyro_x_word;
    logic [15:0] gyro_y_word;
    logic [15:0] gyro_z_word;
    logic [5:0]  write_mask;
    logic        done_res;
  } out_t;

  typedef struct packed {
    logic [WORD_W-1:0] trim;
    logic [WORD_W-1:0] sum;
    logic              zeroed;
  } axis_res_t;

endpackage

`default_nettype wire

// ===== sv/imuaz_axis.sv =====
// One axis of the auto-zero step: sign step of the trim, offset sum, zeroed test.
// Depends on imuaz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imuaz_axis (
  input  wire logic signed [15:0]                   reading,
  input  wire logic [imuaz_pkg::WORD_W-1:0]         trim,
  input  wire logic [imuaz_pkg::WORD_W-1:0]         factory,
  input  wire logic [imuaz_pkg::LIMIT_W-1:0]        limit,
  output imuaz_pkg::axis_res_t                      res
);
  import imuaz_pkg::*;

  logic [WORD_W-1:0] trim_step;
  logic [WORD_W-1:0] mag;

  always_comb begin
    if (reading > 16'sd0) begin
      trim_step = trim - WORD_W'(1);
    end else if (reading < 16'sd0) begin
      trim_step = trim + WORD_W'(1);
    end else begin
      trim_step = trim;
    end
  end

  // -32768 maps to 32768 unsigned, above any limit
  assign mag = reading[15] ? (~reading + WORD_W'(1)) : reading;

  assign res.trim   = trim_step;
  assign res.sum    = trim_step + factory;
  assign res.zeroed = (mag <= {1'b0, limit});

endmodule

`default_nettype wire

// ===== sv/imu_offset_auto_zero_core.sv =====
// Six-axis IMU offset auto-zero core: per-axis sign-step trim counters.
// Each result is registered in the output register, valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the output register accepts a new
// input in the cycle its result is taken.
// Reset (rst_n, synchronous): axes idle, trims zero, factory offsets zero,
// error limit 5, no result pending. Depends on imuaz_pkg and imuaz_axis.
`timescale 1ns / 1ps
`default_nettype none

module imu_offset_auto_zero_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire imuaz_pkg::in_t                        in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output imuaz_pkg::out_t                            out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [imuaz_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [imuaz_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import imuaz_pkg::*;

  logic [WORD_W-1:0]   factory_r [NUM_AXES];
  logic [LIMIT_W-1:0]  limit_r;
  logic [WORD_W-1:0]   trim_r    [NUM_AXES];
  logic [WORD_W-1:0]   trim_nxt  [NUM_AXES];
  logic [NUM_AXES-1:0] active_r, active_nxt;
  logic                skip_r, skip_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;

  logic signed [15:0]  reading [NUM_AXES];
  axis_res_t           res     [NUM_AXES];
  logic [WORD_W-1:0]   word    [NUM_AXES];
  logic [NUM_AXES-1:0] mask;
  logic [NUM_AXES-1:0] still;
  logic                in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign reading[0] = in_data.accel_x;
  assign reading[1] = in_data.accel_y;
  assign reading[2] = in_data.accel_z;
  assign reading[3] = in_data.gyro_x;
  assign reading[4] = in_data.gyro_y;
  assign reading[5] = in_data.gyro_z;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    imuaz_axis u_axis (
      .reading (reading[g]),
      .trim    (trim_r[g]),
      .factory (factory_r[g]),
      .limit   (limit_r),
      .res     (res[g])
    );
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        factory_r[i] <= '0;
      end
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ACCEL_X_FACTORY: factory_r[0] <= {cfg_wdata[ACC_FAC_W-1], cfg_wdata[ACC_FAC_W-1:0]};
        REG_ACCEL_Y_FACTORY: factory_r[1] <= {cfg_wdata[ACC_FAC_W-1], cfg_wdata[ACC_FAC_W-1:0]};
        REG_ACCEL_Z_FACTORY: factory_r[2] <= {cfg_wdata[ACC_FAC_W-1], cfg_wdata[ACC_FAC_W-1:0]};
        REG_GYRO_X_FACTORY:  factory_r[3] <= cfg_wdata;
        REG_GYRO_Y_FACTORY:  factory_r[4] <= cfg_wdata;
        REG_GYRO_Z_FACTORY:  factory_r[5] <= cfg_wdata;
        REG_ERROR_LIMIT:     limit_r      <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      trim_nxt[i] = trim_r[i];
      word[i]     = '0;
    end
    active_nxt    = active_r;
    skip_nxt      = skip_r;
    mask          = '0;
    still         = active_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (in_data.command == CMD_START) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          trim_nxt[i] = '0;
        end
        active_nxt = ALL_AXES;
        skip_nxt   = 1'b1;
      end else if (skip_r) begin
        skip_nxt = 1'b0;
      end else begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (active_r[i]) begin
            trim_nxt[i] = res[i].trim;
            mask[i]     = 1'b1;
            word[i]     = (i < NUM_ACCEL) ? {res[i].sum[WORD_W-2:0], 1'b0} : res[i].sum;
            if (res[i].zeroed) begin
              still[i] = 1'b0;
            end
          end
        end
        active_nxt = still;
      end
      out_nxt.accel_x_word = word[0];
      out_nxt.accel_y_word = word[1];
      out_nxt.accel_z_word = word[2];
      out_nxt.gyro_x_word  = word[3];
      out_nxt.gyro_y_word  = word[4];
      out_nxt.gyro_z_word  = word[5];
      out_nxt.write_mask   = mask;
      out_nxt.done_res     = (in_data.command != CMD_START) && (active_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        trim_r[i] <= '0;
      end
      active_r    <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_AXES; i++) begin
        trim_r[i] <= trim_nxt[i];
      end
      active_r    <= active_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command == CMD_START |=> active_r == ALL_AXES && skip_r && out_valid_r)
    else $error("start transaction did not arm calibration");

  a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command == CMD_SAMPLE && skip_r |=> out_r.write_mask == '0 && !skip_r)
    else $error("discarded sample produced writes");

  a_done_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> active_r == '0)
    else $error("done flagged with axes still active");

  a_no_new_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~$past(active_r)) != '0 |-> $past(in_fire && in_data.command == CMD_START))
    else $error("axis became active without start");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for imu_offset_auto_zero_core: a directed table, then random calibration
// runs over several register settings and idle patterns, checked by a behavioral model.
// Depends on imuaz_pkg and the core RTL.

module tb;
  import imuaz_pkg::*;

  typedef struct packed {
    logic typed;
    in_t  stim;
    out_t want;
  } row_t;

  localparam out_t NO_WRITE  = '0;
  localparam out_t IDLE_DONE = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'h0, 1'b1};
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HOLD_CYCLES     = 60;
  localparam int SEND_IDLE [4]   = '{0, 81, 0, 9};
  localparam int RECV_STALL [4]  = '{0, 0, 81, 9};

  localparam int N_DIRECTED = 23;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, '{CMD_SAMPLE, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006},
      IDLE_DONE},
    '{1'b1, '{CMD_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0005},
      '{16'hFFFE, 16'h0002, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 6'h3F, 1'b0}},
    '{1'b0, '{CMD_SAMPLE, 16'h0006, 16'hFFFA, 16'h0007, 16'h0007, 16'h0007, 16'h0007},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'hFFFB, 16'h0064, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'h1234, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001},
      IDLE_DONE},
    '{1'b1, '{CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      NO_WRITE},
    '{1'b1, '{CMD_START, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      NO_WRITE},
    '{1'b1, '{CMD_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h0064},
      NO_WRITE},
    '{1'b1, '{CMD_START, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 16'h0064},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'hFF9C, 16'hFF9C, 16'hFF9C, 16'hFF9C, 16'hFF9C, 16'hFF9C},
      NO_WRITE},
    '{1'b0, '{CMD_SAMPLE, 16'hFFFB, 16'h0005, 16'hFFFC, 16'h0004, 16'h0000, 16'h0003},
      NO_WRITE},
    '{1'b1, '{CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
      IDLE_DONE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [15:0]         trim [NUM_AXES];
  logic [15:0]         factory [NUM_AXES];
  logic [LIMIT_W-1:0]  err_limit;
  logic [NUM_AXES-1:0] active;
  logic                skip_next;
  out_t                pending_words [$];
  int                  errors = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  holds_asked = 0;
  int                  holds_given = 0;
  int                  hold_left = 0;

  imu_offset_auto_zero_core dut (.*);

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void model_reset();
    for (int i = 0; i < NUM_AXES; i++) begin
      trim[i] = '0;
      factory[i] = '0;
    end
    err_limit = LIMIT_RST;
    active = '0;
    skip_next = 1'b0;
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [15:0] v);
    case (idx)
      REG_ACCEL_X_FACTORY, REG_ACCEL_Y_FACTORY, REG_ACCEL_Z_FACTORY:
        factory[int'(idx)] = {v[14], v[14:0]};
      REG_GYRO_X_FACTORY, REG_GYRO_Y_FACTORY, REG_GYRO_Z_FACTORY:
        factory[int'(idx)] = v;
      REG_ERROR_LIMIT:
        err_limit = v[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic out_t calib_step(in_t x);
    out_t                r;
    logic signed [15:0]  rd [NUM_AXES];
    logic [15:0]         word [NUM_AXES];
    logic [15:0]         sum;
    logic [NUM_AXES-1:0] still;
    int                  rv;
    int                  mag;
    r = '0;
    rd = '{x.accel_x, x.accel_y, x.accel_z, x.gyro_x, x.gyro_y, x.gyro_z};
    word = '{default: '0};
    if (x.command == CMD_START) begin
      for (int i = 0; i < NUM_AXES; i++) trim[i] = '0;
      active = ALL_AXES;
      skip_next = 1'b1;
      return r;
    end
    if (skip_next) begin
      skip_next = 1'b0;
      r.done_res = (active == '0);
      return r;
    end
    still = active;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (active[i]) begin
        rv = rd[i];
        mag = (rv < 0) ? -rv : rv;
        if (rv > 0) trim[i] = trim[i] - 16'd1;
        else if (rv < 0) trim[i] = trim[i] + 16'd1;
        sum = trim[i] + factory[i];
        word[i] = (i < NUM_ACCEL) ? {sum[14:0], 1'b0} : sum;
        r.write_mask[i] = 1'b1;
        if (mag <= int'(err_limit)) still[i] = 1'b0;
      end
    end
    active = still;
    r.accel_x_word = word[0];
    r.accel_y_word = word[1];
    r.accel_z_word = word[2];
    r.gyro_x_word = word[3];
    r.gyro_y_word = word[4];
    r.gyro_z_word = word[5];
    r.done_res = (active == '0);
    return r;
  endfunction

  // Readings biased toward the deadband, zero and the extremes.
  function automatic logic [15:0] rand_reading();
    int span;
    span = int'(err_limit) + 3;
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(2 * span) - span);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t  x;
    logic quiet;
    quiet = (active == '0) && !skip_next;
    x.command = ($urandom_range(quiet ? 1 : 24) == 0) ? CMD_START : CMD_SAMPLE;
    x.accel_x = rand_reading();
    x.accel_y = rand_reading();
    x.accel_z = rand_reading();
    x.gyro_x = rand_reading();
    x.gyro_y = rand_reading();
    x.gyro_z = rand_reading();
    return x;
  endfunction

  task automatic send_item(in_t x, logic typed, out_t want);
    out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = calib_step(x);
    pending_words.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] vals [NUM_AXES+1]);
    for (int i = 0; i <= NUM_AXES; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      apply_reg(reg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (holds_given < holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_given++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got %h", $time, out_data);
      end else begin
        want = pending_words.pop_front();
        check_field("accel_x_word", want.accel_x_word, out_data.accel_x_word);
        check_field("accel_y_word", want.accel_y_word, out_data.accel_y_word);
        check_field("accel_z_word", want.accel_z_word, out_data.accel_z_word);
        check_field("gyro_x_word", want.gyro_x_word, out_data.gyro_x_word);
        check_field("gyro_y_word", want.gyro_y_word, out_data.gyro_y_word);
        check_field("gyro_z_word", want.gyro_z_word, out_data.gyro_z_word);
        check_field("write_mask", 16'(want.write_mask), 16'(out_data.write_mask));
        check_field("done_res", 16'(want.done_res), 16'(out_data.done_res));
      end
    end
  end

  initial begin
    logic [15:0] vals [NUM_AXES+1];
    in_t         x;
    int          counted;
    int          sent;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1: vals = '{16'h3FFF, 16'h3FFF, 16'h3FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000};
          2: vals = '{16'h4000, 16'h4000, 16'h4000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF};
          default: begin
            foreach (vals[i]) vals[i] = 16'($urandom);
            if (p == 3) vals[REG_ERROR_LIMIT] = 16'($urandom_range(40));
            else if (p == 4) vals[REG_ERROR_LIMIT] = 16'($urandom_range(2000));
            else vals[REG_ERROR_LIMIT] = 16'(LIMIT_RST);
          end
        endcase
        configure(vals);
      end
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      if (p == 0)
        for (int i = 0; i < N_DIRECTED; i++)
          send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
      counted = 0;
      sent = 0;
      while (counted < ITEMS_PER_PHASE) begin
        x = rand_item();
        // samples while idle do not count toward the phase
        if (x.command == CMD_START || active != '0 || skip_next) counted++;
        send_item(x, 1'b0, NO_WRITE);
        sent++;
        if (sent == 20) holds_asked++;
        if (sent == 100) wait_drained();
      end
    end
    wait_drained();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
